>>> rtl/core/ncl_pkg.sv
// Shared constants, opcodes and the label color table for the centroid labeler.
`default_nettype none

package ncl_pkg;

   localparam int MAX_CLUSTERS_DEF = 20;
   localparam int SAMPLE_BITS_DEF  = 16;
   localparam int COUNT_BITS_DEF   = 16;

   localparam int SUM_BITS       = 32;
   localparam int CLUSTER_BITS   = 5;
   localparam int LABEL_BITS     = 5;
   localparam int CFG_BITS       = 5;
   localparam int COLOR_BITS     = 8;
   localparam int COLOR_ENTRIES  = 20;

   typedef logic [1:0] op_type;
   typedef logic [3*COLOR_BITS-1:0] rgb_type;

   localparam op_type OP_SEED     = 2'd0;
   localparam op_type OP_FINISH   = 2'd1;
   localparam op_type OP_CLASSIFY = 2'd2;

   function automatic rgb_type label_rgb(input logic [LABEL_BITS-1:0] idx);
      rgb_type rgb;
      case (idx)
         5'd0:    rgb = {8'd255, 8'd0,   8'd0};
         5'd1:    rgb = {8'd0,   8'd255, 8'd0};
         5'd2:    rgb = {8'd0,   8'd0,   8'd255};
         5'd3:    rgb = {8'd165, 8'd42,  8'd42};
         5'd4:    rgb = {8'd210, 8'd105, 8'd30};
         5'd5:    rgb = {8'd189, 8'd183, 8'd107};
         5'd6:    rgb = {8'd139, 8'd0,   8'd139};
         5'd7:    rgb = {8'd255, 8'd140, 8'd0};
         5'd8:    rgb = {8'd153, 8'd50,  8'd204};
         5'd9:    rgb = {8'd0,   8'd206, 8'd209};
         5'd10:   rgb = {8'd255, 8'd20,  8'd147};
         5'd11:   rgb = {8'd105, 8'd105, 8'd105};
         5'd12:   rgb = {8'd255, 8'd215, 8'd0};
         5'd13:   rgb = {8'd75,  8'd0,   8'd130};
         5'd14:   rgb = {8'd0,   8'd0,   8'd128};
         5'd15:   rgb = {8'd192, 8'd192, 8'd192};
         5'd16:   rgb = {8'd0,   8'd128, 8'd128};
         5'd17:   rgb = {8'd255, 8'd255, 8'd0};
         5'd18:   rgb = {8'd154, 8'd205, 8'd50};
         5'd19:   rgb = {8'd240, 8'd255, 8'd255};
         default: rgb = '0;
      endcase
      return rgb;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/ncl_if.sv
// Channel interfaces of the centroid labeler: request, response and register write.
`default_nettype none

interface ncl_req_if
   import ncl_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
   logic                           valid;
   logic                           ready;
   op_type                         op;
   logic [CLUSTER_BITS-1:0]        cluster;
   logic signed [SAMPLE_BITS-1:0]  sample_a;
   logic signed [SAMPLE_BITS-1:0]  sample_b;

   modport source (output valid, op, cluster, sample_a, sample_b, input ready);
   modport sink   (input valid, op, cluster, sample_a, sample_b, output ready);
endinterface

interface ncl_rsp_if
   import ncl_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [LABEL_BITS-1:0]   label;
   logic [COLOR_BITS-1:0]   red;
   logic [COLOR_BITS-1:0]   green;
   logic [COLOR_BITS-1:0]   blue;

   modport source (output valid, label, red, green, blue, input ready);
   modport sink   (input valid, label, red, green, blue, output ready);
endinterface

interface ncl_csr_if
   import ncl_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CFG_BITS-1:0]   clusters_in_use;

   modport source (output valid, clusters_in_use, input ready);
   modport sink   (input valid, clusters_in_use, output ready);
endinterface

`default_nettype wire

>>> rtl/core/two_channel_nearest_centroid_labeler_core.sv
// Top level of the two-channel nearest-centroid labeler.
//
//  channel   dir  modport  payload                             transaction
//  req_chan  in   sink     op, cluster, sample_a, sample_b     seed, finish or classify
//  rsp_chan  out  source   label, red, green, blue             one per classify
//  csr_chan  in   sink     clusters_in_use                     register write
//
// Seed: accumulator read, then write back. Finish: a 36-step bit-serial divider forms
// the means; when the count is zero the means are zero and no steps run. Classify:
// n = clusters in use (at least 1), one centre read per cycle through a square /
// compare pipeline; the response is registered once the scan has drained.
// One transaction is in work at a time; a response still waiting holds the next
// classify in its last cycle, and req_chan with it.
// Reset clears per-entry valid bits, so all sums, counts and centres read as zero.
`default_nettype none

module two_channel_nearest_centroid_labeler_core
   import ncl_pkg::*;
#(
   parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
   parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ncl_req_if.sink    req_chan,
   ncl_rsp_if.source  rsp_chan,
   ncl_csr_if.sink    csr_chan
);

   localparam int IDX_BITS    = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
   localparam int NUM_BITS    = $clog2(MAX_CLUSTERS + 1);
   localparam int CENTRE_BITS = SAMPLE_BITS + 5;
   localparam int DIFF_BITS   = SAMPLE_BITS + 6;
   localparam int MAG_BITS    = SAMPLE_BITS + 5;
   localparam int SQ_BITS     = 2 * MAG_BITS;
   localparam int DIST_BITS   = SQ_BITS + 1;
   localparam int SUM_EXT     = SUM_BITS + 1;
   localparam int ACC_BITS    = 2 * SUM_BITS + COUNT_BITS;
   localparam int CEN_W       = 2 * CENTRE_BITS;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ACC  = 3'd1;
   localparam logic [2:0] ST_FIN  = 3'd2;
   localparam logic [2:0] ST_SCAN = 3'd3;
   localparam logic [2:0] ST_RSP  = 3'd4;

   function automatic logic [SUM_BITS-1:0] sat_add(input logic signed [SUM_BITS-1:0] s,
                                                   input logic signed [SAMPLE_BITS-1:0] x);
      logic signed [SUM_EXT-1:0] r;
      r = SUM_EXT'(s) + SUM_EXT'(x);
      if (r[SUM_EXT-1] != r[SUM_EXT-2]) begin
         return r[SUM_EXT-1] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
      end
      return r[SUM_BITS-1:0];
   endfunction

   logic [2:0]                     state_ff, state_in;
   op_type                         op_ff, op_in;
   logic [IDX_BITS-1:0]            idx_ff, idx_in;
   logic signed [SAMPLE_BITS-1:0]  samp_a_ff, samp_a_in;
   logic signed [SAMPLE_BITS-1:0]  samp_b_ff, samp_b_in;
   logic [NUM_BITS-1:0]            n_ff, n_in;
   logic [CFG_BITS-1:0]            cfg_ff, cfg_in;
   logic [MAX_CLUSTERS-1:0]        acc_valid_ff, acc_valid_in;
   logic [MAX_CLUSTERS-1:0]        cen_valid_ff, cen_valid_in;
   logic [NUM_BITS-1:0]            rd_idx_ff, rd_idx_in;
   logic                           p1_vld_ff, p1_vld_in;
   logic [IDX_BITS-1:0]            p1_idx_ff, p1_idx_in;
   logic                           p2_vld_ff, p2_vld_in;
   logic [IDX_BITS-1:0]            p2_idx_ff, p2_idx_in;
   logic [SQ_BITS-1:0]             sq_a_ff, sq_a_in;
   logic [SQ_BITS-1:0]             sq_b_ff, sq_b_in;
   logic [IDX_BITS-1:0]            best_idx_ff, best_idx_in;
   logic [DIST_BITS-1:0]           best_dist_ff, best_dist_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [LABEL_BITS-1:0]          rsp_label_ff, rsp_label_in;
   rgb_type                        rsp_rgb_ff, rsp_rgb_in;

   logic [ACC_BITS-1:0]            acc_mem [MAX_CLUSTERS];
   logic [ACC_BITS-1:0]            acc_rd_ff;
   logic [CEN_W-1:0]               cen_mem [MAX_CLUSTERS];
   logic [CEN_W-1:0]               cen_rd_ff;
   logic                           cen_rd_ok_ff;

   logic                           req_fire;
   logic                           in_range;
   logic [IDX_BITS-1:0]            req_idx;
   logic [NUM_BITS-1:0]            n_eff;
   logic [IDX_BITS-1:0]            acc_ra;
   logic                           acc_we;
   logic [ACC_BITS-1:0]            acc_wd;
   logic                           acc_ok;
   logic signed [SUM_BITS-1:0]     cur_sum_a, cur_sum_b;
   logic [COUNT_BITS-1:0]          cur_cnt;
   logic                           issue;
   logic [IDX_BITS-1:0]            cen_ra;
   logic                           cen_we;
   logic signed [CENTRE_BITS-1:0]  cen_a, cen_b;
   logic signed [DIFF_BITS-1:0]    diff_a, diff_b;
   logic [MAG_BITS-1:0]            mag_a, mag_b;
   logic [DIST_BITS-1:0]           cand_dist;
   logic                           rsp_load;
   logic                           mean_start;
   logic                           mean_done;
   logic signed [CENTRE_BITS-1:0]  mean_a, mean_b;

   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign in_range       = int'(req_chan.cluster) < MAX_CLUSTERS;
   assign req_idx        = IDX_BITS'(req_chan.cluster);
   assign acc_ra         = in_range ? req_idx : '0;
   assign csr_chan.ready = 1'b1;

   always_comb begin
      if (cfg_ff == '0) begin
         n_eff = NUM_BITS'(1);
      end else if (int'(cfg_ff) > MAX_CLUSTERS) begin
         n_eff = NUM_BITS'(MAX_CLUSTERS);
      end else begin
         n_eff = NUM_BITS'(cfg_ff);
      end
   end

   assign acc_ok    = acc_valid_ff[idx_ff];
   assign cur_sum_a = acc_ok ? acc_rd_ff[ACC_BITS-1 -: SUM_BITS] : '0;
   assign cur_sum_b = acc_ok ? acc_rd_ff[COUNT_BITS +: SUM_BITS] : '0;
   assign cur_cnt   = acc_ok ? acc_rd_ff[COUNT_BITS-1:0] : '0;
   assign acc_wd    = {sat_add(cur_sum_a, samp_a_ff), sat_add(cur_sum_b, samp_b_ff),
                       cur_cnt + 1'b1};

   assign issue  = (state_ff == ST_SCAN) && (rd_idx_ff < n_ff);
   assign cen_ra = issue ? IDX_BITS'(rd_idx_ff) : '0;

   // distance pipeline: centre read, squares, sum and compare
   always_comb begin
      cen_a     = cen_rd_ok_ff ? cen_rd_ff[CEN_W-1 -: CENTRE_BITS] : '0;
      cen_b     = cen_rd_ok_ff ? cen_rd_ff[CENTRE_BITS-1:0] : '0;
      diff_a    = (DIFF_BITS'(samp_a_ff) <<< 4) - DIFF_BITS'(cen_a);
      diff_b    = (DIFF_BITS'(samp_b_ff) <<< 4) - DIFF_BITS'(cen_b);
      mag_a     = MAG_BITS'(diff_a[DIFF_BITS-1] ? -diff_a : diff_a);
      mag_b     = MAG_BITS'(diff_b[DIFF_BITS-1] ? -diff_b : diff_b);
      sq_a_in   = SQ_BITS'(mag_a) * SQ_BITS'(mag_a);
      sq_b_in   = SQ_BITS'(mag_b) * SQ_BITS'(mag_b);
      cand_dist = DIST_BITS'(sq_a_ff) + DIST_BITS'(sq_b_ff);
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      samp_a_in    = samp_a_ff;
      samp_b_in    = samp_b_ff;
      n_in         = n_ff;
      cfg_in       = cfg_ff;
      acc_valid_in = acc_valid_ff;
      cen_valid_in = cen_valid_ff;
      rd_idx_in    = rd_idx_ff;
      p1_vld_in    = issue;
      p1_idx_in    = IDX_BITS'(rd_idx_ff);
      p2_vld_in    = p1_vld_ff;
      p2_idx_in    = p1_idx_ff;
      best_idx_in  = best_idx_ff;
      best_dist_in = best_dist_ff;
      acc_we       = 1'b0;
      cen_we       = 1'b0;
      mean_start   = 1'b0;
      rsp_load     = 1'b0;

      if (csr_chan.valid && csr_chan.ready) begin
         cfg_in = csr_chan.clusters_in_use;
      end
      if (issue) begin
         rd_idx_in = rd_idx_ff + 1'b1;
      end
      if (p2_vld_ff && ((p2_idx_ff == '0) || (cand_dist < best_dist_ff))) begin
         best_idx_in  = p2_idx_ff;
         best_dist_in = cand_dist;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in     = req_chan.op;
               idx_in    = req_idx;
               samp_a_in = req_chan.sample_a;
               samp_b_in = req_chan.sample_b;
               if ((req_chan.op inside {OP_SEED, OP_FINISH}) && in_range) begin
                  state_in = ST_ACC;
               end else if (req_chan.op == OP_CLASSIFY) begin
                  n_in      = n_eff;
                  rd_idx_in = '0;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_ACC: begin
            if (op_ff == OP_SEED) begin
               if (!(&cur_cnt)) begin
                  acc_we               = 1'b1;
                  acc_valid_in[idx_ff] = 1'b1;
               end
               state_in = ST_IDLE;
            end else begin
               mean_start           = 1'b1;
               acc_valid_in[idx_ff] = 1'b0;
               state_in             = ST_FIN;
            end
         end
         ST_FIN: begin
            if (mean_done) begin
               cen_we               = 1'b1;
               cen_valid_in[idx_ff] = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if ((rd_idx_ff == n_ff) && !p1_vld_ff && !p2_vld_ff) begin
               state_in = ST_RSP;
            end
         end
         ST_RSP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_label_in = rsp_label_ff;
      rsp_rgb_in   = rsp_rgb_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_label_in = LABEL_BITS'(best_idx_ff);
         rsp_rgb_in   = (int'(best_idx_ff) < COLOR_ENTRIES) ?
                        label_rgb(LABEL_BITS'(best_idx_ff)) : '0;
      end
   end

   ncl_mean #(
      .COUNT_BITS  (COUNT_BITS),
      .CENTRE_BITS (CENTRE_BITS)
   ) u_mean (
      .clock    (clock),
      .reset    (reset),
      .start    (mean_start),
      .sum_a    (cur_sum_a),
      .sum_b    (cur_sum_b),
      .count    (cur_cnt),
      .done     (mean_done),
      .centre_a (mean_a),
      .centre_b (mean_b)
   );

   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[idx_ff] <= acc_wd;
      end
      acc_rd_ff <= acc_mem[acc_ra];
   end

   always_ff @(posedge clock) begin
      if (cen_we) begin
         cen_mem[idx_ff] <= {mean_a, mean_b};
      end
      cen_rd_ff    <= cen_mem[cen_ra];
      cen_rd_ok_ff <= cen_valid_ff[cen_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_ff       <= CFG_BITS'(1);
         acc_valid_ff <= '0;
         cen_valid_ff <= '0;
         p1_vld_ff    <= 1'b0;
         p2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_idx_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         acc_valid_ff <= acc_valid_in;
         cen_valid_ff <= cen_valid_in;
         p1_vld_ff    <= p1_vld_in;
         p2_vld_ff    <= p2_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_idx_ff    <= rd_idx_in;
      end
      op_ff        <= op_in;
      idx_ff       <= idx_in;
      samp_a_ff    <= samp_a_in;
      samp_b_ff    <= samp_b_in;
      n_ff         <= n_in;
      p1_idx_ff    <= p1_idx_in;
      p2_idx_ff    <= p2_idx_in;
      sq_a_ff      <= sq_a_in;
      sq_b_ff      <= sq_b_in;
      best_idx_ff  <= best_idx_in;
      best_dist_ff <= best_dist_in;
      rsp_label_ff <= rsp_label_in;
      rsp_rgb_ff   <= rsp_rgb_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.label = rsp_label_ff;
   assign rsp_chan.red   = rsp_rgb_ff[3*COLOR_BITS-1 -: COLOR_BITS];
   assign rsp_chan.green = rsp_rgb_ff[COLOR_BITS +: COLOR_BITS];
   assign rsp_chan.blue  = rsp_rgb_ff[COLOR_BITS-1:0];

`ifndef NO_ASSERTIONS
   a_mean_in_fin: assert property (@(posedge clock) disable iff (reset)
      mean_done |-> state_ff == ST_FIN)
      else $error("mean result outside finish state");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> rd_idx_ff <= n_ff)
      else $error("centre read index past cluster count");
   a_best_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RSP |-> NUM_BITS'(best_idx_ff) < n_ff)
      else $error("winning label outside compared clusters");
   a_acc_after_req: assert property (@(posedge clock) disable iff (reset)
      acc_we |-> $past(req_chan.valid && req_chan.ready))
      else $error("accumulator write without a preceding transaction");
   a_pipe_in_scan: assert property (@(posedge clock) disable iff (reset)
      p2_vld_ff |-> state_ff == ST_SCAN)
      else $error("distance pipeline busy outside scan");
`endif

endmodule

`default_nettype wire

>>> rtl/core/ncl_mean.sv
// Two-lane restoring divider that turns cluster sums and a count into rounded Q.4 means.
`default_nettype none

module ncl_mean
   import ncl_pkg::*;
#(
   parameter int COUNT_BITS  = COUNT_BITS_DEF,
   parameter int CENTRE_BITS = SAMPLE_BITS_DEF + 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [SUM_BITS-1:0]    sum_a,
   input  logic signed [SUM_BITS-1:0]    sum_b,
   input  logic [COUNT_BITS-1:0]         count,
   output logic                          done,
   output logic signed [CENTRE_BITS-1:0] centre_a,
   output logic signed [CENTRE_BITS-1:0] centre_b
);

   localparam int DVD_BITS  = SUM_BITS + 4;
   localparam int STEP_BITS = $clog2(DVD_BITS);
   localparam int REM_EXT   = COUNT_BITS + 1;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [STEP_BITS-1:0]     step_ff, step_in;
   logic [COUNT_BITS-1:0]    divisor_ff, divisor_in;
   logic [DVD_BITS-1:0]      quot_ff [2];
   logic [DVD_BITS-1:0]      quot_in [2];
   logic [COUNT_BITS-1:0]    rem_ff [2];
   logic [COUNT_BITS-1:0]    rem_in [2];
   logic                     neg_ff [2];
   logic                     neg_in [2];

   logic signed [SUM_BITS-1:0] sum_sel [2];
   logic [SUM_BITS-1:0]        mag [2];
   logic [REM_EXT-1:0]         shifted [2];
   logic                       ge [2];
   logic [CENTRE_BITS-1:0]     qmag [2];

   always_comb begin
      sum_sel[0] = sum_a;
      sum_sel[1] = sum_b;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      divisor_in = divisor_ff;
      for (int l = 0; l < 2; l++) begin
         mag[l]     = sum_sel[l][SUM_BITS-1] ? SUM_BITS'(-sum_sel[l]) : SUM_BITS'(sum_sel[l]);
         shifted[l] = {rem_ff[l], quot_ff[l][DVD_BITS-1]};
         ge[l]      = shifted[l] >= REM_EXT'(divisor_ff);
         quot_in[l] = quot_ff[l];
         rem_in[l]  = rem_ff[l];
         neg_in[l]  = neg_ff[l];
         if (start) begin
            rem_in[l] = '0;
            if (count == '0) begin
               quot_in[l] = '0;
               neg_in[l]  = 1'b0;
            end else begin
               quot_in[l] = {mag[l], 4'b0} + DVD_BITS'(count >> 1);
               neg_in[l]  = sum_sel[l][SUM_BITS-1];
            end
         end else if (busy_ff) begin
            quot_in[l] = {quot_ff[l][DVD_BITS-2:0], ge[l]};
            rem_in[l]  = ge[l] ? COUNT_BITS'(shifted[l] - REM_EXT'(divisor_ff))
                               : COUNT_BITS'(shifted[l]);
         end
         qmag[l] = CENTRE_BITS'(quot_ff[l]);
      end
      if (start) begin
         divisor_in = count;
         step_in    = '0;
         if (count == '0) begin
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_BITS'(DVD_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff    <= step_in;
      divisor_ff <= divisor_in;
      for (int l = 0; l < 2; l++) begin
         quot_ff[l] <= quot_in[l];
         rem_ff[l]  <= rem_in[l];
         neg_ff[l]  <= neg_in[l];
      end
   end

   assign done     = done_ff;
   assign centre_a = neg_ff[0] ? -$signed(qmag[0]) : $signed(qmag[0]);
   assign centre_b = neg_ff[1] ? -$signed(qmag[1]) : $signed(qmag[1]);

`ifndef NO_ASSERTIONS
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("mean unit started while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("mean done held more than one cycle");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff[0] < divisor_ff) && (rem_ff[1] < divisor_ff))
      else $error("partial remainder not below divisor");
`endif

endmodule

`default_nettype wire
